// File: hdl/strr_pkg.sv
// Shared types and constants for the shuffle table random range core.
package strr_pkg;

  localparam int unsigned RAW_W   = 15;
  localparam int unsigned BOUND_W = 31;
  localparam int unsigned PROD_W  = RAW_W + BOUND_W;
  localparam int unsigned CNT_W   = $clog2(PROD_W + 1);

  localparam int unsigned TABLE_DEPTH_DEF = 98;

  localparam logic [BOUND_W-1:0] SOURCE_MAX  = 31'd32767;
  localparam logic [BOUND_W-1:0] FULL_SCALE  = 31'h7FFF_FFFF;
  localparam logic [BOUND_W-1:0] SPLIT_LIMIT = FULL_SCALE / SOURCE_MAX;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  typedef enum logic {
    MD_MUL,
    MD_DIV
  } md_op_e;

  typedef struct packed {
    logic   start;
    md_op_e op;
  } md_req_t;

  typedef enum logic [1:0] {
    BR_MULDIV,
    BR_DIVMUL,
    BR_RECIP
  } sc_br_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_IDX_MUL,
    S_IDX_DIV,
    S_RD,
    S_RDW,
    S_SC1,
    S_SC2,
    S_FIN
  } state_e;

endpackage

// File: hdl/shuffle_table_random_range_core.sv
// Top level: shuffle table after a 15-bit random source, with range scaling.
//
//  channel | direction | beat fields                           | handshake
//  --------+-----------+---------------------------------------+----------------------
//  in      | to core   | opcode, raw_value, upper_bound        | in_valid_i/in_ready_o
//  out     | from core | shuffled_value, scaled_value          | out_valid_o/out_ready_i
//
// Load beat: no result. Zero-bound draw: goes straight through S_FIN to the output register.
// Draw: 4 passes through the serial mul/div unit (index multiply and divide, then two
// scaling passes), with a table read between the index passes and the scaling passes.
// One beat in flight; the next beat is taken while a finished result waits.
// Reset clears control, last drawn value and load pointer; table holds garbage until loaded.
module shuffle_table_random_range_core #(
  parameter int unsigned TABLE_DEPTH = strr_pkg::TABLE_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         opcode_i,
  input  logic [strr_pkg::RAW_W-1:0]   raw_value_i,
  input  logic [strr_pkg::BOUND_W-1:0] upper_bound_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [strr_pkg::RAW_W-1:0]   shuffled_value_o,
  output logic [strr_pkg::BOUND_W-1:0] scaled_value_o
);
  import strr_pkg::*;

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned PTR_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [PTR_W-1:0]  DEPTH_PTR  = PTR_W'(TABLE_DEPTH);
  localparam logic [PROD_W-1:0] LAST_IDX_W = PROD_W'(TABLE_DEPTH - 1);

  state_e             state_q, state_d;
  logic               issued_q, issued_d;
  logic [PTR_W-1:0]   ptr_q, ptr_d;
  logic [RAW_W-1:0]   last_q, last_d;
  logic               out_valid_q, out_valid_d;
  logic [RAW_W-1:0]   shuf_q, shuf_d;
  logic [BOUND_W-1:0] scaled_q, scaled_d;
  sc_br_e             br_q, br_d;
  logic [RAW_W-1:0]   raw_q, raw_d;
  logic [BOUND_W-1:0] bound_q, bound_d;
  logic [RAW_W-1:0]   v_q, v_d;
  logic [PROD_W-1:0]  tmp_q, tmp_d;

  logic [RAW_W-1:0]   table_mem [TABLE_DEPTH];
  logic [RAW_W-1:0]   rd_q;
  logic               mem_we, mem_re;
  logic [IDX_W-1:0]   mem_addr;
  logic [RAW_W-1:0]   mem_wdata;
  logic [IDX_W-1:0]   draw_idx;

  md_req_t            md_req;
  logic [BOUND_W-1:0] md_mcand;
  logic [RAW_W-1:0]   md_mplier;
  logic [PROD_W-1:0]  md_dividend;
  logic [BOUND_W-1:0] md_divisor;
  logic [PROD_W-1:0]  md_result;
  logic               md_done;
  logic               in_fire;

  strr_muldiv u_muldiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (md_req),
    .mcand_i    (md_mcand),
    .mplier_i   (md_mplier),
    .dividend_i (md_dividend),
    .divisor_i  (md_divisor),
    .result_o   (md_result),
    .done_o     (md_done)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign draw_idx   = (tmp_q > LAST_IDX_W) ? LAST_IDX : tmp_q[IDX_W-1:0];

  always_comb begin
    state_d     = state_q;
    issued_d    = issued_q;
    ptr_d       = ptr_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    shuf_d      = shuf_q;
    scaled_d    = scaled_q;
    br_d        = br_q;
    raw_d       = raw_q;
    bound_d     = bound_q;
    v_d         = v_q;
    tmp_d       = tmp_q;

    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = draw_idx;
    mem_wdata = raw_q;

    md_req.start = 1'b0;
    md_req.op    = MD_MUL;
    md_mcand     = '0;
    md_mplier    = '0;
    md_dividend  = '0;
    md_divisor   = SOURCE_MAX;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (opcode_i == OP_LOAD) begin
            if (ptr_q < DEPTH_PTR) begin
              mem_we    = 1'b1;
              mem_addr  = ptr_q[IDX_W-1:0];
              mem_wdata = raw_value_i;
              ptr_d     = ptr_q + 1'b1;
            end else begin
              last_d = raw_value_i;
              ptr_d  = '0;
            end
          end else if (upper_bound_i == '0) begin
            bound_d = '0;
            v_d     = '0;
            tmp_d   = '0;
            state_d = S_FIN;
          end else begin
            raw_d   = raw_value_i;
            bound_d = upper_bound_i;
            if (upper_bound_i < SOURCE_MAX) begin
              br_d = BR_RECIP;
            end else if (upper_bound_i < SPLIT_LIMIT) begin
              br_d = BR_MULDIV;
            end else begin
              br_d = BR_DIVMUL;
            end
            state_d = S_IDX_MUL;
          end
        end
      end
      S_IDX_MUL: begin
        md_req.op = MD_MUL;
        md_mcand  = BOUND_W'(TABLE_DEPTH - 1);
        md_mplier = last_q;
      end
      S_IDX_DIV: begin
        md_req.op   = MD_DIV;
        md_dividend = tmp_q;
        md_divisor  = SOURCE_MAX;
      end
      S_RD: begin
        mem_re  = 1'b1;
        mem_we  = 1'b1;
        state_d = S_RDW;
      end
      S_RDW: begin
        v_d     = rd_q;
        last_d  = rd_q;
        state_d = S_SC1;
      end
      S_SC1: begin
        case (br_q)
          BR_MULDIV: begin
            md_req.op = MD_MUL;
            md_mcand  = bound_q;
            md_mplier = v_q;
          end
          BR_DIVMUL: begin
            md_req.op   = MD_DIV;
            md_dividend = PROD_W'(bound_q);
            md_divisor  = SOURCE_MAX;
          end
          default: begin
            md_req.op   = MD_DIV;
            md_dividend = PROD_W'(SOURCE_MAX);
            md_divisor  = bound_q + 1'b1;
          end
        endcase
      end
      S_SC2: begin
        case (br_q)
          BR_MULDIV: begin
            md_req.op   = MD_DIV;
            md_dividend = tmp_q;
            md_divisor  = SOURCE_MAX;
          end
          BR_DIVMUL: begin
            md_req.op = MD_MUL;
            md_mcand  = tmp_q[BOUND_W-1:0];
            md_mplier = v_q;
          end
          default: begin
            md_req.op   = MD_DIV;
            md_dividend = PROD_W'(v_q);
            md_divisor  = tmp_q[BOUND_W-1:0];
          end
        endcase
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          shuf_d      = v_q;
          scaled_d    = (tmp_q > PROD_W'(bound_q)) ? bound_q : tmp_q[BOUND_W-1:0];
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (state_q == S_IDX_MUL || state_q == S_IDX_DIV ||
        state_q == S_SC1 || state_q == S_SC2) begin
      if (!issued_q) begin
        md_req.start = 1'b1;
        issued_d     = 1'b1;
      end else if (md_done) begin
        issued_d = 1'b0;
        tmp_d    = md_result;
        case (state_q)
          S_IDX_MUL: state_d = S_IDX_DIV;
          S_IDX_DIV: state_d = S_RD;
          S_SC1:     state_d = S_SC2;
          default:   state_d = S_FIN;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      issued_q    <= 1'b0;
      ptr_q       <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
      br_q        <= BR_RECIP;
    end else begin
      state_q     <= state_d;
      issued_q    <= issued_d;
      ptr_q       <= ptr_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
      br_q        <= br_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shuf_q   <= shuf_d;
    scaled_q <= scaled_d;
    raw_q    <= raw_d;
    bound_q  <= bound_d;
    v_q      <= v_d;
    tmp_q    <= tmp_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_q <= table_mem[mem_addr];
    end
    if (mem_we) begin
      table_mem[mem_addr] <= mem_wdata;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign shuffled_value_o = shuf_q;
  assign scaled_value_o   = scaled_q;

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= DEPTH_PTR)
    else $error("load pointer beyond table depth");

  a_done_in_compute: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_done |-> (state_q == S_IDX_MUL || state_q == S_IDX_DIV ||
                 state_q == S_SC1 || state_q == S_SC2))
    else $error("serial unit finished outside a compute state");

  a_load_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && opcode_i == OP_LOAD) |=> (state_q == S_IDLE && !$rose(out_valid_q)))
    else $error("load beat started work or produced a result");

  a_draw_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && (!out_valid_q || out_ready_i)) |=> (out_valid_q && in_ready_o))
    else $error("finished draw not moved into output register");

endmodule

// File: hdl/strr_muldiv.sv
// Bit-serial shift-add multiplier and restoring divider, one bit per cycle.
module strr_muldiv (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  strr_pkg::md_req_t            req_i,
  input  logic [strr_pkg::BOUND_W-1:0] mcand_i,
  input  logic [strr_pkg::RAW_W-1:0]   mplier_i,
  input  logic [strr_pkg::PROD_W-1:0]  dividend_i,
  input  logic [strr_pkg::BOUND_W-1:0] divisor_i,
  output logic [strr_pkg::PROD_W-1:0]  result_o,
  output logic                         done_o
);
  import strr_pkg::*;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  md_op_e             op_q, op_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [PROD_W-1:0]  acc_q, acc_d;
  logic [PROD_W-1:0]  mc_q, mc_d;
  logic [RAW_W-1:0]   mp_q, mp_d;
  logic [BOUND_W-1:0] rem_q, rem_d;
  logic [BOUND_W-1:0] dv_q, dv_d;
  logic [BOUND_W:0]   trial;
  logic [BOUND_W:0]   diff;
  logic               fits;

  always_comb begin
    trial = {rem_q, acc_q[PROD_W-1]};
    diff  = trial - {1'b0, dv_q};
    fits  = trial >= {1'b0, dv_q};

    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    mc_d   = mc_q;
    mp_d   = mp_q;
    rem_d  = rem_q;
    dv_d   = dv_q;

    if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      rem_d  = '0;
      dv_d   = divisor_i;
      mc_d   = PROD_W'(mcand_i);
      mp_d   = mplier_i;
      if (req_i.op == MD_MUL) begin
        acc_d = '0;
        cnt_d = CNT_W'(RAW_W);
      end else begin
        acc_d = dividend_i;
        cnt_d = CNT_W'(PROD_W);
      end
    end else if (busy_q) begin
      case (op_q)
        MD_MUL: begin
          if (mp_q[0]) begin
            acc_d = acc_q + mc_q;
          end
          mc_d = {mc_q[PROD_W-2:0], 1'b0};
          mp_d = {1'b0, mp_q[RAW_W-1:1]};
        end
        MD_DIV: begin
          rem_d = fits ? diff[BOUND_W-1:0] : trial[BOUND_W-1:0];
          acc_d = {acc_q[PROD_W-2:0], fits};
        end
        default: begin
          acc_d = acc_q;
        end
      endcase
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= MD_MUL;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    mc_q  <= mc_d;
    mp_q  <= mp_d;
    rem_q <= rem_d;
    dv_q  <= dv_d;
  end

  assign result_o = acc_q;
  assign done_o   = done_q;

endmodule
